[src/land_change_proximity_allocator_macros.svh]
// Assertion macros for the land change proximity allocator.
`ifndef LAND_CHANGE_PROXIMITY_ALLOCATOR_MACROS_SVH
`define LAND_CHANGE_PROXIMITY_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lcpa_pkg.sv]
// Package: item types, register indexes and status codes of the allocator.
`default_nettype none
package lcpa_pkg;

    localparam int CLASS_W = 8;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } lcpa_kind_t;

    typedef enum logic [1:0] {
        ST_LOADING = 2'd0,
        ST_READY   = 2'd1,
        ST_NOCHG   = 2'd2,
        ST_NOCAND  = 2'd3
    } lcpa_status_t;

    typedef enum logic [2:0] {
        REG_COLUMNS     = 3'd0,
        REG_ROWS        = 3'd1,
        REG_QUANTITY    = 3'd2,
        REG_NODATA_EN   = 3'd3,
        REG_NODATA_CODE = 3'd4
    } lcpa_reg_t;

    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] class_before;
        logic [CLASS_W-1:0] class_after;
        logic               is_last;
        logic [INDEX_W-1:0] read_index;
    } lcpa_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CLASS_W-1:0] predicted_class;
        logic               was_allocated;
        logic [COUNT_W-1:0] allocated_count;
    } lcpa_out_t;

endpackage
`default_nettype wire

[src/land_change_proximity_allocator.sv]
// Every item taken gives one result; the last load first runs the computation: histogram
// clear, marking of changed cells, class vote, sampling, distances from each candidate
// to the samples, and allocation of the converted cells. One item is taken at a time.
// Reset (aresetn, synchronous, active low) clears control and config; cell maps hold
// no reset and stay undefined until loaded; there is no clearing pass.
`default_nettype none
`include "land_change_proximity_allocator_macros.svh"
module land_change_proximity_allocator #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_SAMPLE  = 5000
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lcpa_pkg::lcpa_in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output lcpa_pkg::lcpa_out_t m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [2:0]           cfg_index,
    input  wire [12:0]          cfg_data
);
    import lcpa_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLUMNS);
    localparam int COLW  = $clog2(MAX_COLUMNS + 1);
    localparam int ROWW  = $clog2(MAX_ROWS + 1);
    localparam int MW    = (RW > CLW) ? RW : CLW;
    localparam int DW    = 2 * MW + 1;
    localparam int XW    = (CW > INDEX_W) ? CW : INDEX_W;
    // reciprocal of MAX_SAMPLE, exact for every count that fits CW bits
    localparam int DSH   = CW + $clog2(MAX_SAMPLE);
    localparam int RCW   = CW + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << DSH) + 64'(MAX_SAMPLE) - 64'd1) / 64'(MAX_SAMPLE);
    localparam logic [RCW-1:0] RECIP_W = RCW'(RECIP);

    typedef enum logic [4:0] {
        S_IDLE, S_RESP, S_CLR, S_MRD, S_MWR, S_MHST, S_TGT,
        S_SRD, S_SCHK, S_DRD, S_DCHK, S_DLOOP, S_DWR, S_ASCAN, S_AMARK,
        S_RWAIT, S_RGET
    } state_t;

    // configuration
    logic [6:0]         cols_cfg_reg, rows_cfg_reg;
    logic [12:0]        qty_cfg_reg;
    logic               nd_en_reg;
    logic [CLASS_W-1:0] nd_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= 7'd64;
            rows_cfg_reg <= 7'd64;
            qty_cfg_reg  <= 13'd100;
            nd_en_reg    <= 1'b0;
            nd_code_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COLUMNS:     cols_cfg_reg <= cfg_data[6:0];
                REG_ROWS:        rows_cfg_reg <= cfg_data[6:0];
                REG_QUANTITY:    qty_cfg_reg  <= cfg_data;
                REG_NODATA_EN:   nd_en_reg    <= cfg_data[0];
                REG_NODATA_CODE: nd_code_reg  <= cfg_data[CLASS_W-1:0];
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // raster size from config
    logic [COLW-1:0]      cols;
    logic [ROWW-1:0]      rows;
    logic [COLW+ROWW-1:0] size_prod;
    logic [CW-1:0]        total;

    always_comb begin
        if (cols_cfg_reg == 7'd0) cols = COLW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLUMNS) cols = COLW'(MAX_COLUMNS);
        else cols = COLW'(cols_cfg_reg);
        if (rows_cfg_reg == 7'd0) rows = ROWW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS) rows = ROWW'(MAX_ROWS);
        else rows = ROWW'(rows_cfg_reg);
    end
    assign size_prod = (COLW+ROWW)'(cols) * (COLW+ROWW)'(rows);
    assign total     = CW'(size_prod);

    // control registers
    state_t             state_reg;
    lcpa_status_t       run_status_reg;
    logic [CW-1:0]      load_pos_reg, run_total_reg, alloc_cnt_reg;
    logic [CW-1:0]      i_reg, n_reg, nc_reg, ns_reg, s_reg, rk_reg, step_reg;
    logic [CW-1:0]      q_reg, k_reg, best_reg, id_reg, pick_reg;
    logic [8:0]         h_reg;
    logic [RW-1:0]      r_reg;
    logic [CLW-1:0]     c_reg;
    logic [DW-1:0]      dmin_reg, d_reg, dbest_reg;
    logic               p1_reg, p2_reg, found_reg;
    logic [CLASS_W-1:0] tgt_reg;
    lcpa_out_t          res_reg;

    // memory read data
    logic [CLASS_W-1:0] bef_q, aft_q;
    logic               chg_q, cand_q, alloc_q;
    logic [DW-1:0]      dist_q;
    logic [CW-1:0]      hist_q;
    logic [RW+CLW-1:0]  smp_q;

    logic s_fire;
    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // cell evaluation
    logic          valid_now, chg_now, is_cand;
    logic [CW-1:0] i_inc;
    logic          cell_last;
    assign valid_now = !(nd_en_reg && (bef_q == nd_code_reg || aft_q == nd_code_reg));
    assign chg_now   = valid_now && (bef_q != aft_q);
    assign is_cand   = !chg_q && !(nd_en_reg && aft_q == nd_code_reg);
    assign i_inc     = i_reg + CW'(1);
    assign cell_last = (i_inc == run_total_reg);

    // squared distance to the sample being read
    logic [RW-1:0]   smp_r;
    logic [CLW-1:0]  smp_c;
    logic [MW-1:0]   dr, dc;
    logic [2*MW-1:0] sqr, sqc;
    logic [DW-1:0]   d_calc;
    assign smp_r  = smp_q[RW+CLW-1:CLW];
    assign smp_c  = smp_q[CLW-1:0];
    assign dr     = MW'((r_reg > smp_r) ? (r_reg - smp_r) : (smp_r - r_reg));
    assign dc     = MW'((c_reg > smp_c) ? (c_reg - smp_c) : (smp_c - c_reg));
    assign sqr    = (2*MW)'(dr) * (2*MW)'(dr);
    assign sqc    = (2*MW)'(dc) * (2*MW)'(dc);
    assign d_calc = DW'(sqr) + DW'(sqc);

    // stride = changed count / MAX_SAMPLE
    logic [CW+RCW-1:0] step_prod;
    assign step_prod = (CW+RCW)'(n_reg) * (CW+RCW)'(RECIP_W);

    logic          col_wrap;
    assign col_wrap = (COLW'(c_reg) + COLW'(1) == cols);

    logic [CW-1:0] nc_new, q_new, cnt_new;
    assign nc_new  = nc_reg + CW'(state_reg == S_DWR);
    assign q_new   = (32'(qty_cfg_reg) < 32'(nc_new)) ? CW'(qty_cfg_reg) : nc_new;
    assign cnt_new = alloc_cnt_reg + CW'(found_reg);

    logic d_issue, a_issue;
    assign d_issue = (s_reg < ns_reg);
    assign a_issue = (i_reg < run_total_reg);

    // memory write controls
    logic          map_we, chg_we, alloc_we, alloc_wd, cand_we, cand_wd, dist_we;
    logic          hist_we, smp_we;
    logic [AW-1:0] alloc_wa;
    logic [7:0]    hist_wa, hist_ra;
    logic [CW-1:0] hist_wd;

    always_comb begin
        map_we   = s_fire && (s_data.kind == KIND_LOAD) && (load_pos_reg < total);
        chg_we   = (state_reg == S_MWR);
        alloc_we = (state_reg == S_MWR) || ((state_reg == S_AMARK) && found_reg);
        alloc_wd = (state_reg == S_AMARK);
        alloc_wa = (state_reg == S_AMARK) ? pick_reg[AW-1:0] : i_reg[AW-1:0];
        cand_we  = ((state_reg == S_DCHK) && !is_cand) || (state_reg == S_DWR);
        cand_wd  = (state_reg == S_DWR);
        dist_we  = (state_reg == S_DWR);
        hist_we  = (state_reg == S_CLR) || (state_reg == S_MHST);
        hist_wa  = (state_reg == S_CLR) ? h_reg[7:0] : aft_q;
        hist_wd  = (state_reg == S_CLR) ? '0 : hist_q + CW'(1);
        hist_ra  = (state_reg == S_TGT) ? h_reg[7:0] : aft_q;
        smp_we   = (state_reg == S_SCHK) && chg_q && (rk_reg == '0);
    end

    // memories
    logic [CLASS_W-1:0] bef_mem [CELLS];
    logic [CLASS_W-1:0] aft_mem [CELLS];
    logic               chg_mem [CELLS];
    logic               cand_mem [CELLS];
    logic               alloc_mem [CELLS];
    logic [DW-1:0]      dist_mem [CELLS];
    logic [CW-1:0]      hist_mem [256];
    logic [RW+CLW-1:0]  smp_mem [CELLS];

    always_ff @(posedge aclk) begin
        if (map_we) begin
            bef_mem[load_pos_reg[AW-1:0]] <= s_data.class_before;
            aft_mem[load_pos_reg[AW-1:0]] <= s_data.class_after;
        end
        bef_q <= bef_mem[i_reg[AW-1:0]];
        aft_q <= aft_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (chg_we) chg_mem[i_reg[AW-1:0]] <= chg_now;
        chg_q <= chg_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cand_we) cand_mem[i_reg[AW-1:0]] <= cand_wd;
        cand_q <= cand_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (alloc_we) alloc_mem[alloc_wa] <= alloc_wd;
        alloc_q <= alloc_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) dist_mem[i_reg[AW-1:0]] <= dmin_reg;
        dist_q <= dist_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) hist_mem[hist_wa] <= hist_wd;
        hist_q <= hist_mem[hist_ra];
    end

    always_ff @(posedge aclk) begin
        if (smp_we) smp_mem[ns_reg[AW-1:0]] <= {r_reg, c_reg};
        smp_q <= smp_mem[s_reg[AW-1:0]];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            run_status_reg <= ST_LOADING;
            load_pos_reg   <= '0;
            run_total_reg  <= '0;
            alloc_cnt_reg  <= '0;
            tgt_reg        <= '0;
            m_valid        <= 1'b0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != S_RESP) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (s_data.kind == KIND_LOAD) begin
                            run_status_reg <= ST_LOADING;
                            if (s_data.is_last) begin
                                load_pos_reg  <= '0;
                                run_total_reg <= total;
                                alloc_cnt_reg <= '0;
                                h_reg         <= '0;
                                state_reg     <= S_CLR;
                            end else begin
                                if (load_pos_reg < total) load_pos_reg <= load_pos_reg + CW'(1);
                                res_reg   <= '{ST_LOADING, '0, 1'b0, '0};
                                state_reg <= S_RESP;
                            end
                        end else if (run_status_reg == ST_READY &&
                                     XW'(s_data.read_index) < XW'(run_total_reg)) begin
                            i_reg     <= CW'(s_data.read_index);
                            state_reg <= S_RWAIT;
                        end else begin
                            res_reg <= '{run_status_reg, '0, 1'b0,
                                (run_status_reg != ST_LOADING) ? COUNT_W'(alloc_cnt_reg) : '0};
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_RWAIT: state_reg <= S_RGET;
                S_RGET: begin
                    res_reg <= '{ST_READY, alloc_q ? tgt_reg : aft_q, alloc_q,
                                 COUNT_W'(alloc_cnt_reg)};
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid || m_ready) begin
                        m_valid   <= 1'b1;
                        m_data    <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_CLR: begin
                    h_reg <= h_reg + 9'd1;
                    if (h_reg == 9'd255) begin
                        i_reg     <= '0;
                        n_reg     <= '0;
                        state_reg <= S_MRD;
                    end
                end
                S_MRD: state_reg <= S_MWR;
                S_MWR, S_MHST: begin
                    if (state_reg == S_MWR && chg_now) begin
                        state_reg <= S_MHST;
                    end else begin
                        if (state_reg == S_MHST) n_reg <= n_reg + CW'(1);
                        if (cell_last) begin
                            if (state_reg == S_MWR && n_reg == '0) begin
                                run_status_reg <= ST_NOCHG;
                                res_reg   <= '{ST_NOCHG, '0, 1'b0, '0};
                                state_reg <= S_RESP;
                            end else begin
                                h_reg     <= '0;
                                best_reg  <= '0;
                                tgt_reg   <= '0;
                                state_reg <= S_TGT;
                            end
                        end else begin
                            i_reg     <= i_inc;
                            state_reg <= S_MRD;
                        end
                    end
                end
                S_TGT: begin
                    h_reg <= h_reg + 9'd1;
                    if (h_reg != 9'd0 && hist_q > best_reg) begin
                        best_reg <= hist_q;
                        tgt_reg  <= CLASS_W'(h_reg - 9'd1);
                    end
                    if (h_reg == 9'd256) begin
                        i_reg  <= '0;
                        r_reg  <= '0;
                        c_reg  <= '0;
                        rk_reg <= '0;
                        ns_reg <= '0;
                        if (32'(n_reg) > MAX_SAMPLE) step_reg <= CW'(step_prod >> DSH);
                        else step_reg <= CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_SRD: state_reg <= S_SCHK;
                S_SCHK: begin
                    if (chg_q) begin
                        if (rk_reg == '0) ns_reg <= ns_reg + CW'(1);
                        rk_reg <= (rk_reg == step_reg - CW'(1)) ? '0 : rk_reg + CW'(1);
                    end
                    if (cell_last) begin
                        i_reg     <= '0;
                        r_reg     <= '0;
                        c_reg     <= '0;
                        nc_reg    <= '0;
                        state_reg <= S_DRD;
                    end else begin
                        i_reg <= i_inc;
                        if (col_wrap) begin
                            c_reg <= '0;
                            r_reg <= r_reg + RW'(1);
                        end else begin
                            c_reg <= c_reg + CLW'(1);
                        end
                        state_reg <= S_SRD;
                    end
                end
                S_DRD: state_reg <= S_DCHK;
                S_DLOOP: begin
                    if (d_issue) s_reg <= s_reg + CW'(1);
                    p1_reg <= d_issue;
                    if (p1_reg) d_reg <= d_calc;
                    p2_reg <= p1_reg;
                    if (p2_reg && d_reg < dmin_reg) dmin_reg <= d_reg;
                    if (!d_issue && !p1_reg && !p2_reg) state_reg <= S_DWR;
                end
                S_DCHK, S_DWR: begin
                    if (state_reg == S_DCHK && is_cand) begin
                        s_reg     <= '0;
                        dmin_reg  <= '1;
                        p1_reg    <= 1'b0;
                        p2_reg    <= 1'b0;
                        state_reg <= S_DLOOP;
                    end else begin
                        nc_reg <= nc_new;
                        if (cell_last) begin
                            if (nc_new == '0) begin
                                run_status_reg <= ST_NOCAND;
                                res_reg   <= '{ST_NOCAND, '0, 1'b0, '0};
                                state_reg <= S_RESP;
                            end else if (q_new == '0) begin
                                run_status_reg <= ST_READY;
                                res_reg   <= '{ST_READY, '0, 1'b0, '0};
                                state_reg <= S_RESP;
                            end else begin
                                q_reg     <= q_new;
                                k_reg     <= '0;
                                i_reg     <= '0;
                                p1_reg    <= 1'b0;
                                found_reg <= 1'b0;
                                state_reg <= S_ASCAN;
                            end
                        end else begin
                            i_reg <= i_inc;
                            if (col_wrap) begin
                                c_reg <= '0;
                                r_reg <= r_reg + RW'(1);
                            end else begin
                                c_reg <= c_reg + CLW'(1);
                            end
                            state_reg <= S_DRD;
                        end
                    end
                end
                S_ASCAN: begin
                    if (a_issue) i_reg <= i_inc;
                    p1_reg <= a_issue;
                    id_reg <= i_reg;
                    // first strictly smaller distance wins, so ties keep the lower index
                    if (p1_reg && cand_q && !alloc_q && (!found_reg || dist_q < dbest_reg)) begin
                        found_reg <= 1'b1;
                        dbest_reg <= dist_q;
                        pick_reg  <= id_reg;
                    end
                    if (!a_issue && !p1_reg) state_reg <= S_AMARK;
                end
                S_AMARK: begin
                    alloc_cnt_reg <= cnt_new;
                    k_reg         <= k_reg + CW'(1);
                    if (!found_reg || k_reg + CW'(1) == q_reg) begin
                        run_status_reg <= ST_READY;
                        res_reg   <= '{ST_READY, '0, 1'b0, COUNT_W'(cnt_new)};
                        state_reg <= S_RESP;
                    end else begin
                        i_reg     <= '0;
                        p1_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        state_reg <= S_ASCAN;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LCPA_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken while busy")
    `LCPA_ASSERT_NOW(a_alloc_ready, m_valid && m_data.was_allocated,
        m_data.status == ST_READY, "allocated flag without ready status")
    `LCPA_ASSERT_NOW(a_pred_zero, m_valid && m_data.status != ST_READY,
        m_data.predicted_class == '0 && !m_data.was_allocated, "class given while not ready")

endmodule
`default_nettype wire

[sim/land_change_proximity_allocator_tb.sv]
// Self-checking testbench for the land change proximity allocator, with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module land_change_proximity_allocator_tb;
    import lcpa_pkg::*;

    localparam int CELLS  = 4096;
    localparam int MAXDIM = 64;
    localparam int NITEMS = 950;

    typedef enum int {
        PH_MIXED, PH_NOCHANGE, PH_ALLCHANGE, PH_FIRSTND, PH_EARLY, PH_EXTRA
    } phase_kind_t;

    typedef struct {
        lcpa_in_t  item;
        lcpa_out_t result;
    } cell_job_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    lcpa_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    lcpa_out_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;

    land_change_proximity_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // allocator shadow state
    bit [7:0]    before_cls[CELLS];
    bit [7:0]    after_cls[CELLS];
    bit          changed[CELLS];
    bit          candidate[CELLS];
    bit          converted[CELLS];
    bit          ever_loaded[CELLS];
    int unsigned near_dsq[CELLS];
    int unsigned samp_r[CELLS];
    int unsigned samp_c[CELLS];
    int unsigned dest_votes[256];
    int unsigned sh_cols = 64, sh_rows = 64, sh_qty = 100, sh_nden = 0, sh_ndcode = 0;
    int unsigned target_cls = 0, load_pos = 0, run_state = 0, run_cells = 0, conv_total = 0;

    cell_job_t   job_q[$];
    lcpa_out_t   due_q[$];
    int          n_gen = 0, n_acc = 0, n_res = 0, n_fail = 0, n_runs = 0, n_phases = 0;
    int          hold_left = 0;
    bit          hold_done = 0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v == 0) return 1;
        return v > MAXDIM ? MAXDIM : v;
    endfunction

    function automatic void allocate_run();
        int unsigned cols, total, nd, n, ns, nc, stride, rank, q, best, pick, dbest;
        bit found, ok;
        cols = clamp_dim(sh_cols);
        total = cols * clamp_dim(sh_rows);
        nd = sh_ndcode & 8'hFF;
        n = 0; ns = 0; nc = 0; rank = 0;
        run_cells = total;
        conv_total = 0;
        for (int i = 0; i < CELLS; i++) begin
            converted[i] = 0;
            candidate[i] = 0;
        end
        for (int c = 0; c < 256; c++) dest_votes[c] = 0;
        for (int i = 0; i < total; i++) begin
            ok = !(sh_nden != 0 && (before_cls[i] == nd || after_cls[i] == nd));
            changed[i] = ok && before_cls[i] != after_cls[i];
            if (changed[i]) begin
                n++;
                dest_votes[after_cls[i]]++;
            end
        end
        if (n == 0) begin
            run_state = ST_NOCHG;
            return;
        end
        stride = n > 5000 ? n / 5000 : 1;
        for (int i = 0; i < total; i++) begin
            if (!changed[i]) continue;
            if (rank % stride == 0) begin
                samp_r[ns] = i / cols;
                samp_c[ns] = i % cols;
                ns++;
            end
            rank++;
        end
        for (int i = 0; i < total; i++) begin
            int unsigned r, c, dmin, dr, dc;
            r = i / cols;
            c = i % cols;
            dmin = 32'hFFFF_FFFF;
            if (changed[i]) continue;
            if (sh_nden != 0 && after_cls[i] == nd) continue;
            for (int s = 0; s < ns; s++) begin
                dr = r > samp_r[s] ? r - samp_r[s] : samp_r[s] - r;
                dc = c > samp_c[s] ? c - samp_c[s] : samp_c[s] - c;
                if (dr * dr + dc * dc < dmin) dmin = dr * dr + dc * dc;
            end
            near_dsq[i] = dmin;
            candidate[i] = 1;
            nc++;
        end
        if (nc == 0) begin
            run_state = ST_NOCAND;
            return;
        end
        target_cls = 0;
        best = 0;
        for (int c = 0; c < 256; c++) begin
            if (dest_votes[c] > best) begin
                best = dest_votes[c];
                target_cls = c;
            end
        end
        q = sh_qty < nc ? sh_qty : nc;
        for (int k = 0; k < q; k++) begin
            found = 0;
            pick = 0;
            dbest = 32'hFFFF_FFFF;
            for (int i = 0; i < total; i++) begin
                if (!candidate[i] || converted[i]) continue;
                if (!found || near_dsq[i] < dbest) begin
                    found = 1;
                    dbest = near_dsq[i];
                    pick = i;
                end
            end
            if (!found) break;
            converted[pick] = 1;
            conv_total++;
        end
        run_state = ST_READY;
    endfunction

    function automatic lcpa_out_t predict_cell_step(lcpa_in_t it);
        lcpa_out_t o;
        int unsigned total;
        o = '0;
        if (it.kind == KIND_LOAD) begin
            total = clamp_dim(sh_cols) * clamp_dim(sh_rows);
            run_state = ST_LOADING;
            if (load_pos < total) begin
                before_cls[load_pos] = it.class_before;
                after_cls[load_pos] = it.class_after;
                ever_loaded[load_pos] = 1;
                load_pos++;
            end
            if (it.is_last) begin
                allocate_run();
                load_pos = 0;
                o.allocated_count = COUNT_W'(conv_total);
                n_runs++;
            end
        end else begin
            if (run_state != ST_LOADING) o.allocated_count = COUNT_W'(conv_total);
            if (run_state == ST_READY && it.read_index < run_cells) begin
                o.was_allocated = converted[it.read_index];
                o.predicted_class = converted[it.read_index] ? CLASS_W'(target_cls)
                                                             : after_cls[it.read_index];
            end
        end
        o.status = run_state[1:0];
        return o;
    endfunction

    function automatic void queue_item(lcpa_in_t it);
        cell_job_t j;
        j.item = it;
        j.result = predict_cell_step(it);
        job_q = {job_q, j};
        n_gen++;
    endfunction

    function automatic void queue_load(bit [7:0] b, bit [7:0] a, bit last);
        lcpa_in_t it;
        it = '0;
        it.kind = KIND_LOAD;
        it.class_before = b;
        it.class_after = a;
        it.is_last = last;
        it.read_index = 12'($urandom); // ignored on loads
        queue_item(it);
    endfunction

    function automatic void queue_read(bit [11:0] idx);
        lcpa_in_t it;
        it = '0;
        it.kind = KIND_READ;
        it.class_before = 8'($urandom);
        it.class_after = 8'($urandom);
        it.is_last = 1'($urandom);
        it.read_index = idx;
        queue_item(it);
    endfunction

    // no cell inside the run's raster may be one that was never loaded
    function automatic bit [11:0] safe_index();
        bit [11:0] idx;
        idx = 12'($urandom);
        if ($urandom_range(0, 9) < 7 && run_cells > 0) idx = 12'($urandom_range(0, run_cells - 1));
        if (idx < run_cells && !ever_loaded[idx]) idx = 0;
        return idx;
    endfunction

    function automatic bit [7:0] pick_class();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 12) return 8'($urandom);
        if (p < 25) return 8'(sh_ndcode);
        return 8'($urandom_range(0, 3));
    endfunction

    task automatic drain();
        do @(posedge aclk); while (job_q.size() != 0 || s_valid || due_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(lcpa_reg_t r, int unsigned v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= 13'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (r)
            REG_COLUMNS:     sh_cols = v & 7'h7F;
            REG_ROWS:        sh_rows = v & 7'h7F;
            REG_QUANTITY:    sh_qty = v & 13'h1FFF;
            REG_NODATA_EN:   sh_nden = v & 1;
            REG_NODATA_CODE: sh_ndcode = v & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic run_phase(int unsigned c, int unsigned r, int unsigned q, int unsigned en,
                             int unsigned nd, phase_kind_t style);
        int unsigned total, nload;
        bit [7:0] b, a;
        bit all_in;
        drain();
        cfg_write(REG_COLUMNS, c);
        cfg_write(REG_ROWS, r);
        cfg_write(REG_QUANTITY, q);
        cfg_write(REG_NODATA_EN, en);
        cfg_write(REG_NODATA_CODE, nd);
        n_phases++;
        total = clamp_dim(sh_cols) * clamp_dim(sh_rows);
        all_in = 1;
        for (int i = 0; i < total; i++) if (!ever_loaded[i]) all_in = 0;
        queue_read(safe_index());
        nload = total;
        if (style == PH_EARLY && all_in) nload = $urandom_range(1, total);
        if (style == PH_EXTRA) nload = total + $urandom_range(1, 4);
        for (int i = 0; i < nload; i++) begin
            b = pick_class();
            case (style)
                PH_NOCHANGE:  a = b;
                PH_ALLCHANGE: begin
                    b = 8'($urandom);
                    a = 8'(b + $urandom_range(1, 255));
                end
                PH_FIRSTND: begin
                    a = pick_class();
                    if ($urandom_range(0, 2) == 0) begin
                        b = 8'(sh_ndcode);
                        a = 8'(sh_ndcode + 1);
                    end
                end
                default: a = $urandom_range(0, 9) < 6 ? b : pick_class();
            endcase
            if ($urandom_range(0, 19) == 0) queue_read(safe_index());
            queue_load(b, a, i == nload - 1);
        end
        if (total <= 16) begin
            for (int i = 0; i < total; i++) queue_read(12'(i));
        end
        repeat ($urandom_range(4, 12)) queue_read(safe_index());
        queue_read(12'hFFF);
    endtask

    // sender
    always @(posedge aclk) begin
        cell_job_t done;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                done = job_q.pop_front();
                due_q = {due_q, done.result};
                n_acc++;
            end
            if (job_q.size() > 0
                    && ((n_acc > 400 && n_acc < 550) || $urandom_range(0, 99) >= 18)) begin
                s_valid <= 1'b1;
                s_data  <= job_q[0].item;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        lcpa_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_res++;
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    n_fail++;
                end else begin
                    want = due_q.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        n_fail++;
                    end
                    if (m_data.predicted_class !== want.predicted_class) begin
                        $display("%0t: predicted_class expected %0d actual %0d",
                                 $time, want.predicted_class, m_data.predicted_class);
                        n_fail++;
                    end
                    if (m_data.was_allocated !== want.was_allocated) begin
                        $display("%0t: was_allocated expected %0d actual %0d",
                                 $time, want.was_allocated, m_data.was_allocated);
                        n_fail++;
                    end
                    if (m_data.allocated_count !== want.allocated_count) begin
                        $display("%0t: allocated_count expected %0d actual %0d",
                                 $time, want.allocated_count, m_data.allocated_count);
                        n_fail++;
                    end
                end
                if (n_res == 300 && !hold_done) begin
                    hold_left = 400;
                    hold_done = 1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (n_acc > 400 && n_acc < 550) || $urandom_range(0, 99) >= 18;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: corners and special cases
        run_phase(4, 4, 3, 0, 0, PH_MIXED);
        run_phase(4, 4, 3, 1, 0, PH_NOCHANGE);
        run_phase(3, 2, 5, 0, 0, PH_ALLCHANGE);
        run_phase(4, 4, 4, 1, 2, PH_FIRSTND);
        run_phase(4, 4, 8191, 1, 255, PH_EARLY);
        run_phase(4, 4, 0, 0, 0, PH_EXTRA);
        run_phase(64, 1, 4096, 1, 1, PH_MIXED);
        run_phase(0, 127, 2, 0, 3, PH_MIXED);
        run_phase(127, 0, 1, 1, 0, PH_EARLY);
        run_phase(1, 1, 1, 0, 0, PH_ALLCHANGE);
        // random phases
        while (n_gen < NITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                run_phase($urandom_range(0, 127), $urandom_range(0, 1), $urandom,
                          $urandom_range(0, 1), $urandom, phase_kind_t'($urandom_range(0, 5)));
            end else begin
                run_phase($urandom_range(1, 8), $urandom_range(1, 8),
                          $urandom_range(0, 3) == 0 ? 4096 : $urandom_range(0, 20),
                          $urandom_range(0, 1),
                          $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                          $urandom_range(0, 3) == 0 ? phase_kind_t'($urandom_range(1, 5))
                                                    : PH_MIXED);
            end
        end
        drain();
        repeat (20) @(posedge aclk);
        $display("Ran %0d phases, %0d items, %0d allocation runs, %0d results checked.",
                 n_phases, n_acc, n_runs, n_res);
        if (n_fail == 0 && due_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
